[src/ppc_pkg.sv]
// Package with the constants, types and tables shared by the perfect power classifier.
`timescale 1ns / 1ps

package ppc_pkg;

  localparam int VALUE_BITS   = 31;                    // width of the value field
  localparam int ROOT_BITS    = 16;                    // root of a 31-bit value fits in 16 bits
  localparam int PROD_BITS    = VALUE_BITS + ROOT_BITS; // width of one partial power
  localparam int MASK_BITS    = 16;                    // width of the power mask
  localparam int EXP_BITS     = 5;                     // width of the exponent register
  localparam int BIT_IDX_BITS = 4;                     // indexes the root bits
  localparam int MASK_IDX_BITS = 4;                    // indexes the mask bits

  localparam logic [EXP_BITS-1:0] EXP_RESET = EXP_BITS'(2);
  localparam logic [EXP_BITS-1:0] EXP_LOW   = EXP_BITS'(2);
  localparam logic [EXP_BITS-1:0] EXP_HIGH  = EXP_BITS'(MASK_BITS + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                     load_value;  // capture the request value, clear the mask
    logic                     start_exp;   // clear root and match flag for a new exponent
    logic                     start_trial; // product := candidate
    logic                     mul;         // product := product * candidate
    logic                     take_cand;   // root := candidate, record exact match
    logic                     set_mask;    // mask bit := match flag
    logic                     load_out;    // result register := mask
    logic [BIT_IDX_BITS-1:0]  bit_idx;     // root bit under trial
    logic [MASK_IDX_BITS-1:0] mask_idx;    // mask bit of the current exponent
  } ppc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic over; // partial power has passed the value
  } ppc_status_t;

  // Highest root bit that can be set for exponent k, i.e. ceil(VALUE_BITS / k) - 1.
  function automatic logic [BIT_IDX_BITS-1:0] top_root_bit(input logic [EXP_BITS-1:0] k);
    logic [BIT_IDX_BITS-1:0] res;
    unique case (k)
      5'd2:    res = 4'd15;
      5'd3:    res = 4'd10;
      5'd4:    res = 4'd7;
      5'd5:    res = 4'd6;
      5'd6:    res = 4'd5;
      5'd7:    res = 4'd4;
      5'd8:    res = 4'd3;
      5'd9:    res = 4'd3;
      5'd10:   res = 4'd3;
      5'd11:   res = 4'd2;
      5'd12:   res = 4'd2;
      5'd13:   res = 4'd2;
      5'd14:   res = 4'd2;
      5'd15:   res = 4'd2;
      5'd16:   res = 4'd1;
      5'd17:   res = 4'd1;
      default: res = 4'd15;
    endcase
    return res;
  endfunction

endpackage

[src/ppc_if.sv]
// Interfaces for the request, result and configuration channels.
`timescale 1ns / 1ps

interface ppc_in_if;
  logic                            valid;
  logic                            ready;
  logic [ppc_pkg::VALUE_BITS-1:0]  value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ppc_out_if;
  logic                            valid;
  logic                            ready;
  logic [ppc_pkg::MASK_BITS-1:0]   power_mask;
  modport source (output valid, output power_mask, input ready);
  modport sink   (input valid, input power_mask, output ready);
endinterface

interface ppc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ppc_pkg::EXP_BITS-1:0]    highest_exponent;
  modport source (output valid, output highest_exponent, input ready);
  modport sink   (input valid, input highest_exponent, output ready);
endinterface

[src/perfect_power_classifier.sv]
// Top level of the perfect power classifier: controller, datapath and channel wiring.
`timescale 1ns / 1ps

// Use of the block:
// A request on in_chan carries one 31-bit unsigned value. The block answers
// with exactly one result on out_chan whose power_mask has bit k set when the
// value is an exact power with exponent k+2, for exponents 2 up to the
// configured highest exponent (saturated at 17). Zero gives an empty mask.
// cfg_chan writes the highest exponent; it is always ready. The user must
// write it only while the block is idle; the block does not enforce this.
// Reset (rst_n low, synchronous) sets the highest exponent to 2 and empties
// the controller and result register. Throughput: one request at a time.
// Each exponent k runs a bitwise root search over ceil(31/k) root bits, and
// each trial raises the candidate to the k-th power through the one shared
// 31x16 multiplier, one multiply per cycle, stopping early once the product
// passes the value. Each exponent also passes through S_EXP and S_EXP_END.
// The finished mask sits in an output register; if the receiver stalls, the
// next request is still accepted and computed, and waits only for the slot.
module perfect_power_classifier (
  input  logic        clk,
  input  logic        rst_n,
  ppc_in_if.sink      in_chan,
  ppc_out_if.source   out_chan,
  ppc_cfg_if.sink     cfg_chan
);

  ppc_pkg::ppc_cmd_t    cmd;
  ppc_pkg::ppc_status_t status;

  // The controller owns all handshakes and the exponent register.
  ppc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cfg_valid (cfg_chan.valid),
    .cfg_ready (cfg_chan.ready),
    .cfg_data  (cfg_chan.highest_exponent),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the value, the growing root, the partial power and the mask.
  ppc_dp u_dp (
    .clk      (clk),
    .in_value (in_chan.value),
    .cmd      (cmd),
    .status   (status),
    .out_mask (out_chan.power_mask)
  );

endmodule

[src/ppc_dp.sv]
// Datapath: root search registers, shared multiplier, mask and result register.
`timescale 1ns / 1ps

module ppc_dp (
  input  logic                              clk,
  input  logic [ppc_pkg::VALUE_BITS-1:0]    in_value,
  input  ppc_pkg::ppc_cmd_t                 cmd,
  output ppc_pkg::ppc_status_t              status,
  output logic [ppc_pkg::MASK_BITS-1:0]     out_mask
);

  logic [ppc_pkg::VALUE_BITS-1:0] value_r, value_nxt;
  logic [ppc_pkg::ROOT_BITS-1:0]  root_r, root_nxt;
  logic [ppc_pkg::PROD_BITS-1:0]  prod_r, prod_nxt;
  logic                           match_r, match_nxt;
  logic [ppc_pkg::MASK_BITS-1:0]  mask_r, mask_nxt;
  logic [ppc_pkg::MASK_BITS-1:0]  out_mask_r, out_mask_nxt;
  logic [ppc_pkg::ROOT_BITS-1:0]  cand;
  logic [ppc_pkg::PROD_BITS-1:0]  value_ext;

  // Candidate root: the bits found so far plus the bit under trial.
  assign cand      = root_r | (ppc_pkg::ROOT_BITS'(1) << cmd.bit_idx);
  assign value_ext = ppc_pkg::PROD_BITS'(value_r);

  always_comb begin
    value_nxt    = value_r;
    root_nxt     = root_r;
    prod_nxt     = prod_r;
    match_nxt    = match_r;
    mask_nxt     = mask_r;
    out_mask_nxt = out_mask_r;
    if (cmd.load_value) begin
      value_nxt = in_value;
      mask_nxt  = '0;
    end
    if (cmd.start_exp) begin
      root_nxt  = '0;
      match_nxt = 1'b0;
    end
    if (cmd.start_trial) begin
      prod_nxt = ppc_pkg::PROD_BITS'(cand);
    end
    if (cmd.mul) begin
      // While the product is not above the value its upper bits are zero.
      prod_nxt = ppc_pkg::PROD_BITS'(prod_r[ppc_pkg::VALUE_BITS-1:0])
               * ppc_pkg::PROD_BITS'(cand);
    end
    if (cmd.take_cand) begin
      root_nxt  = cand;
      match_nxt = (prod_r == value_ext);
    end
    if (cmd.set_mask) begin
      mask_nxt[cmd.mask_idx] = match_r;
    end
    if (cmd.load_out) begin
      out_mask_nxt = mask_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    root_r     <= root_nxt;
    prod_r     <= prod_nxt;
    match_r    <= match_nxt;
    mask_r     <= mask_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign status.over = (prod_r > value_ext);
  assign out_mask    = out_mask_r;

endmodule

[src/ppc_ctrl.sv]
// Controller: sequences exponents, root bits and multiplies; holds the configuration register.
`timescale 1ns / 1ps

module ppc_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  output logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ppc_pkg::EXP_BITS-1:0]    cfg_data,
  input  ppc_pkg::ppc_status_t            status,
  output ppc_pkg::ppc_cmd_t               cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXP     = 3'd1;
  localparam logic [2:0] S_TRIAL   = 3'd2;
  localparam logic [2:0] S_POW     = 3'd3;
  localparam logic [2:0] S_EXP_END = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;

  logic [2:0]                          state_r, state_nxt;
  logic [ppc_pkg::EXP_BITS-1:0]        hexp_r, hexp_nxt;
  logic [ppc_pkg::EXP_BITS-1:0]        top_r, top_nxt;
  logic [ppc_pkg::EXP_BITS-1:0]        k_r, k_nxt;
  logic [ppc_pkg::EXP_BITS-1:0]        cnt_r, cnt_nxt;
  logic [ppc_pkg::BIT_IDX_BITS-1:0]    bit_r, bit_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic                                slot_free;
  logic [ppc_pkg::EXP_BITS-1:0]        top_sat;

  assign slot_free = !out_valid_r || out_ready;
  assign top_sat   = (hexp_r > ppc_pkg::EXP_HIGH) ? ppc_pkg::EXP_HIGH : hexp_r;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    hexp_nxt      = hexp_r;
    top_nxt       = top_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.bit_idx   = bit_r;
    cmd.mask_idx  = ppc_pkg::MASK_IDX_BITS'(k_r - ppc_pkg::EXP_LOW);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid) begin
      hexp_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_value = 1'b1;
          top_nxt        = top_sat;
          k_nxt          = ppc_pkg::EXP_LOW;
          state_nxt      = (top_sat < ppc_pkg::EXP_LOW) ? S_FINISH : S_EXP;
        end
      end
      S_EXP: begin
        cmd.start_exp = 1'b1;
        bit_nxt       = ppc_pkg::top_root_bit(k_r);
        state_nxt     = S_TRIAL;
      end
      S_TRIAL: begin
        cmd.start_trial = 1'b1;
        cnt_nxt         = ppc_pkg::EXP_BITS'(1);
        state_nxt       = S_POW;
      end
      S_POW: begin
        if (!status.over && (cnt_r != k_r)) begin
          cmd.mul = 1'b1;
          cnt_nxt = cnt_r + ppc_pkg::EXP_BITS'(1);
        end else begin
          cmd.take_cand = !status.over;
          if (bit_r == '0) begin
            state_nxt = S_EXP_END;
          end else begin
            bit_nxt   = bit_r - ppc_pkg::BIT_IDX_BITS'(1);
            state_nxt = S_TRIAL;
          end
        end
      end
      S_EXP_END: begin
        cmd.set_mask = 1'b1;
        if (k_r == top_r) begin
          state_nxt = S_FINISH;
        end else begin
          k_nxt     = k_r + ppc_pkg::EXP_BITS'(1);
          state_nxt = S_EXP;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hexp_r      <= ppc_pkg::EXP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hexp_r      <= hexp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    bit_r <= bit_nxt;
  end

  // An accepted request always starts work.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("request accepted but controller stayed idle");

  // The power count never runs past the exponent.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POW) |-> (cnt_r <= k_r))
    else $error("power count passed the exponent");

  // Exponent under work stays in the tested range.
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXP || state_r == S_TRIAL || state_r == S_POW || state_r == S_EXP_END)
      |-> (k_r >= ppc_pkg::EXP_LOW && k_r <= ppc_pkg::EXP_HIGH))
    else $error("exponent out of range");

  // A result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

endmodule

[test/ppc_checker.sv]
// Checker for the perfect power classifier: tracks the exponent register and checks every mask.
`timescale 1ns / 1ps

module ppc_checker (
  input  logic clk,
  input  logic rst_n,
  ppc_in_if    in_mon,
  ppc_out_if   out_mon,
  ppc_cfg_if   cfg_mon,
  output int   failures,
  output int   pending
);

  import ppc_pkg::*;

  // The block holds at most one result waiting and one request in work, so a
  // small ring of expected masks is ample.
  localparam int DUE_DEPTH = 16;

  logic [EXP_BITS-1:0]  exp_copy;
  logic [MASK_BITS-1:0] masks_due [DUE_DEPTH];
  int                   due_head   = 0;
  int                   due_count  = 0;
  int                   fail_count = 0;

  // r^k, or cap+1 as soon as the partial power passes cap.
  function automatic longint unsigned power_upto(input longint unsigned r, input int k,
                                                 input longint unsigned cap);
    longint unsigned acc;
    acc = 1;
    for (int i = 0; i < k; i++) begin
      if (r != 0 && acc > cap / r) return cap + 1;
      acc = acc * r;
    end
    return acc;
  endfunction

  // Exact integer k-th root per exponent, then a check that it powers back to the value.
  function automatic logic [MASK_BITS-1:0] predict_power_mask(input logic [VALUE_BITS-1:0] value,
                                                              input logic [EXP_BITS-1:0] highest);
    int                   top_exp;
    longint unsigned      root;
    longint unsigned      trial;
    logic [MASK_BITS-1:0] mask;
    top_exp = (highest > EXP_HIGH) ? int'(EXP_HIGH) : int'(highest);
    mask = '0;
    if (value != '0) begin
      for (int k = 2; k <= top_exp; k++) begin
        root = 0;
        for (int b = ROOT_BITS - 1; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          if (power_upto(trial, k, value) <= value) root = trial;
        end
        if (power_upto(root, k, value) == value) mask[k-2] = 1'b1;
      end
    end
    return mask;
  endfunction

  always @(posedge clk) begin
    logic [MASK_BITS-1:0] due;
    if (!rst_n) begin
      exp_copy  = EXP_RESET;
      due_head  = 0;
      due_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (due_count == 0) begin
          $error("power_mask: expected nothing, actual %h", out_mon.power_mask);
          fail_count++;
        end else begin
          due       = masks_due[due_head];
          due_head  = (due_head + 1) % DUE_DEPTH;
          due_count = due_count - 1;
          if (due !== out_mon.power_mask) begin
            $error("power_mask: expected %h, actual %h", due, out_mon.power_mask);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (due_count == DUE_DEPTH) begin
          $error("power_mask: expected at most %0d outstanding, actual %0d",
                 DUE_DEPTH, due_count + 1);
          fail_count++;
        end else begin
          masks_due[(due_head + due_count) % DUE_DEPTH] =
            predict_power_mask(in_mon.value, exp_copy);
          due_count = due_count + 1;
        end
      end
      if (cfg_mon.valid && cfg_mon.ready)
        exp_copy = cfg_mon.highest_exponent;
    end
    pending  <= due_count;
    failures <= fail_count;
  end

endmodule

[test/tb_perfect_power_classifier.sv]
// Testbench top for the perfect power classifier: clock, reset, requests, settings and verdict.
`timescale 1ns / 1ps

module tb_perfect_power_classifier;

  import ppc_pkg::*;

  // The limit covers about 1200 requests, each at its slowest with every exponent
  // enabled and with a sender gap and a receiver stall on top, several times over.
  localparam int CYCLE_LIMIT   = 3_000_000;
  // Cycles to keep watching after the last mask, long enough for one slow request.
  localparam int SETTLE_CYCLES = 700;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 88;
  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;

  logic clk = 1'b0;
  logic rst_n;
  int   failures;
  int   pending;
  int   cycles = 0;
  int   idle_pct;
  bit   calm;

  // Largest root whose k-th power still fits in the value field, for k = 2 .. 17.
  int unsigned root_limit [2:17];

  // Hand-picked requests: the field extremes, both alternating bit patterns, the
  // largest square and its neighbours, and powers that light up single exponents
  // or many at once (two to the thirtieth, three to the eighteenth).
  logic [VALUE_BITS-1:0] corner_values [] = '{
    31'd0, 31'd1, 31'd2, 31'd4, 31'd8, 31'd9, 31'd65536, 31'd131072,
    31'h4000_0000, 31'h7FFF_FFFF, 31'd2147395600, 31'd2147395599, 31'd2147395601,
    31'd2146689000, 31'd1162261467, 31'd387420489, 31'd1220703125, 31'd1977326743,
    31'd410338673, 31'h5555_5555, 31'h2AAA_AAAA
  };

  // Settings for the random phases: the saturating value with every bit set, the
  // two settings that test nothing, the boundaries around the top exponent and a
  // few ordinary ones. Phases past the end of this list pick a setting at random.
  logic [EXP_BITS-1:0] phase_limits [] = '{
    5'd31, 5'd0, 5'd1, 5'd16, 5'd3, 5'd18, 5'd2, 5'd9
  };

  always #5 clk = ~clk;

  ppc_in_if  in_chan ();
  ppc_out_if out_chan ();
  ppc_cfg_if cfg_chan ();

  perfect_power_classifier u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  ppc_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_chan),
    .out_mon  (out_chan),
    .cfg_mon  (cfg_chan),
    .failures (failures),
    .pending  (pending)
  );

  // Watchdog: a hung block or a lost mask ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: ready stays high for a while, then now and again drops for a burst.
  // In the closing phase the receiver never stalls.
  initial begin
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(1, 100) <= idle_pct) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  // k-th power of base, or one past the value field's maximum once it no longer fits.
  function automatic longint unsigned raise_capped(input longint unsigned base,
                                                   input int unsigned k);
    longint unsigned acc;
    acc = 1;
    repeat (k) begin
      acc = acc * base;
      if (acc > VALUE_MAX) return VALUE_MAX + 1;
    end
    return acc;
  endfunction

  // Presents one request and returns at the edge where it is accepted. Valid is
  // only lowered for a gap, so back-to-back requests keep it high throughout.
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    if (!calm && $urandom_range(1, 100) <= idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.value <= v;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // Waits until every request has had its mask back, so that the block is idle.
  task automatic drain;
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_limit(input logic [EXP_BITS-1:0] e);
    cfg_chan.valid            <= 1'b1;
    cfg_chan.highest_exponent <= e;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
  endtask

  // Random requests. Most are exact powers with a random exponent and root, some
  // of them nudged by one either way; small roots are favoured half of the time so
  // that values with many exponents come up often. The rest is noise over the
  // whole field, short values and the extremes.
  task automatic run_random(input int count);
    int unsigned     k;
    int unsigned     lim;
    int unsigned     root;
    int unsigned     pick;
    longint unsigned v;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        k   = $urandom_range(2, 17);
        lim = root_limit[k];
        if ($urandom_range(0, 1) == 1 && lim > 20) lim = 20;
        root = $urandom_range(2, lim);
        v    = raise_capped(root, k);
        if (pick == 5) v = v + $urandom_range(0, 2) - 1;
      end else if (pick <= 7) begin
        v = $urandom() & VALUE_MAX;
      end else if (pick == 8) begin
        v = ($urandom() & VALUE_MAX) >> $urandom_range(1, 30);
      end else begin
        case ($urandom_range(0, 2))
          0:       v = 0;
          1:       v = 1;
          default: v = VALUE_MAX;
        endcase
      end
      send_value(v[VALUE_BITS-1:0]);
    end
  endtask

  initial begin
    int unsigned lim;
    in_chan.valid             <= 1'b0;
    in_chan.value             <= '0;
    cfg_chan.valid            <= 1'b0;
    cfg_chan.highest_exponent <= EXP_RESET;
    rst_n                     <= 1'b0;
    calm     = 1'b0;
    idle_pct = 20;

    for (int k = 2; k <= 17; k++) begin
      lim = 1;
      while (raise_capped(lim + 1, k) <= VALUE_MAX) lim++;
      root_limit[k] = lim;
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // First a few requests at the reset setting, with only squares tested.
    run_random(40);
    drain();

    // The hand-picked requests with every exponent enabled.
    write_limit(EXP_HIGH);
    foreach (corner_values[i]) send_value(corner_values[i]);
    drain();

    // Random phases, each under its own setting and its own amount of idling;
    // an idle rate of zero gives whole phases that run flat out.
    for (int p = 0; p < PHASES; p++) begin
      if (p < phase_limits.size()) write_limit(phase_limits[p]);
      else write_limit(EXP_BITS'($urandom_range(0, 31)));
      case ($urandom_range(0, 3))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        2:       idle_pct = 30;
        default: idle_pct = 60;
      endcase
      run_random(PHASE_ITEMS);
      drain();
    end

    // Closing phase with no idling on either side.
    calm = 1'b1;
    write_limit(EXP_HIGH);
    run_random(60);
    drain();

    // Keep watching for a while in case a stray mask turns up.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
